@@ design/xed_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xed_pkg
// Types, codes and entity tables shared by the XML entity decoder modules.
// ----------------------------------------------------------------------------
package xed_pkg;

    localparam int FQ_DEPTH  = 2;   // classified item queue
    localparam int RQ_DEPTH  = 2;   // result queue
    localparam int ENT_COUNT = 5;

    typedef enum logic [2:0] {
        MODE_PLAIN,
        MODE_NAMED,
        MODE_HASH,
        MODE_HEXSTART,
        MODE_HEX,
        MODE_DEC,
        MODE_SKIP,
        MODE_DRAIN
    } mode_t;

    // One input byte with its character class worked out
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_amp;
        logic       is_hash;
        logic       is_semi;
        logic       is_x;
        logic       is_dec;
        logic       is_hex;
        logic [3:0] digit;      // value of a decimal or hex digit
        logic       is_cont;    // UTF-8 continuation byte
        logic [1:0] lead_len;   // continuation bytes announced by a lead byte
    } item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       end_of_text;
        logic       decode_error;
    } result_t;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_X    = 8'h78;

    // Length of each named entity after the ampersand, semicolon included
    function automatic logic [2:0] ent_len(input logic [2:0] idx);
        logic [2:0] len;
        begin
            unique case (idx)
                3'd0:    len = 3'd4;   // amp;
                3'd1:    len = 3'd3;   // lt;
                3'd2:    len = 3'd3;   // gt;
                3'd3:    len = 3'd5;   // quot;
                3'd4:    len = 3'd5;   // apos;
                default: len = 3'd0;
            endcase
            return len;
        end
    endfunction

    function automatic logic [7:0] ent_val(input logic [2:0] idx);
        logic [7:0] val;
        begin
            unique case (idx)
                3'd0:    val = 8'h26;
                3'd1:    val = 8'h3c;
                3'd2:    val = 8'h3e;
                3'd3:    val = 8'h22;
                3'd4:    val = 8'h27;
                default: val = 8'h00;
            endcase
            return val;
        end
    endfunction

    function automatic logic [7:0] ent_char(input logic [2:0] idx, input logic [2:0] pos);
        logic [7:0] ch;
        begin
            ch = 8'h00;
            unique case (idx)
                3'd0:
                    unique case (pos)
                        3'd0:    ch = 8'h61;  // a
                        3'd1:    ch = 8'h6d;  // m
                        3'd2:    ch = 8'h70;  // p
                        3'd3:    ch = CH_SEMI;
                        default: ch = 8'h00;
                    endcase
                3'd1:
                    unique case (pos)
                        3'd0:    ch = 8'h6c;  // l
                        3'd1:    ch = 8'h74;  // t
                        3'd2:    ch = CH_SEMI;
                        default: ch = 8'h00;
                    endcase
                3'd2:
                    unique case (pos)
                        3'd0:    ch = 8'h67;  // g
                        3'd1:    ch = 8'h74;  // t
                        3'd2:    ch = CH_SEMI;
                        default: ch = 8'h00;
                    endcase
                3'd3:
                    unique case (pos)
                        3'd0:    ch = 8'h71;  // q
                        3'd1:    ch = 8'h75;  // u
                        3'd2:    ch = 8'h6f;  // o
                        3'd3:    ch = 8'h74;  // t
                        3'd4:    ch = CH_SEMI;
                        default: ch = 8'h00;
                    endcase
                3'd4:
                    unique case (pos)
                        3'd0:    ch = 8'h61;  // a
                        3'd1:    ch = 8'h70;  // p
                        3'd2:    ch = 8'h6f;  // o
                        3'd3:    ch = 8'h73;  // s
                        3'd4:    ch = CH_SEMI;
                        default: ch = 8'h00;
                    endcase
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage
`default_nettype wire

@@ design/xed_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xed_front
// Accepts input bytes, classifies them and holds them in a short queue
// until the decode stage takes them.
// ----------------------------------------------------------------------------
module xed_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [7:0]     in_byte,
    input  wire logic           in_last,
    input  wire logic           push,
    output logic                full,
    output xed_pkg::item_t      item,
    output logic                item_valid,
    input  wire logic           take
);

    xed_pkg::item_t cls;
    xed_pkg::item_t mem_reg [xed_pkg::FQ_DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           wr_en;
    logic           rd_en;

    always_comb
    begin
        cls          = '0;
        cls.data     = in_byte;
        cls.last     = in_last;
        cls.is_amp   = (in_byte == xed_pkg::CH_AMP);
        cls.is_hash  = (in_byte == xed_pkg::CH_HASH);
        cls.is_semi  = (in_byte == xed_pkg::CH_SEMI);
        cls.is_x     = (in_byte == xed_pkg::CH_X);
        cls.is_dec   = (in_byte >= 8'h30) && (in_byte <= 8'h39);
        if (cls.is_dec)
        begin
            cls.is_hex = 1'b1;
            cls.digit  = 4'(in_byte - 8'h30);
        end
        else if ((in_byte >= 8'h41) && (in_byte <= 8'h46))
        begin
            cls.is_hex = 1'b1;
            cls.digit  = 4'(in_byte - 8'h37);
        end
        else if ((in_byte >= 8'h61) && (in_byte <= 8'h66))
        begin
            cls.is_hex = 1'b1;
            cls.digit  = 4'(in_byte - 8'h57);
        end
        cls.is_cont = ((in_byte & 8'hc0) == 8'h80);
        if ((in_byte & 8'he0) == 8'hc0)
            cls.lead_len = 2'd1;
        else if ((in_byte & 8'hf0) == 8'he0)
            cls.lead_len = 2'd2;
        else if ((in_byte & 8'hf8) == 8'hf0)
            cls.lead_len = 2'd3;
    end

    assign full       = (cnt_reg == 2'(xed_pkg::FQ_DEPTH));
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = mem_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = take && item_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        cnt_next    = cnt_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

@@ design/xed_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xed_back
// Decode stage: runs the entity and UTF-8 state machine on one classified
// byte per cycle while the result queue has room, and writes results into it.
// ----------------------------------------------------------------------------
module xed_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire xed_pkg::item_t item,
    input  wire logic           item_valid,
    output logic                take,
    input  wire logic           res_full,
    output logic                res_wr,
    output xed_pkg::result_t    res
);

    xed_pkg::mode_t mode_reg, mode_next;
    logic [4:0]     cand_reg, cand_next;
    logic [2:0]     pos_reg, pos_next;
    logic [7:0]     val_reg, val_next;
    logic [1:0]     pend_reg, pend_next;

    logic       emit;
    logic       err;
    logic       silent;
    logic [7:0] v;
    logic [4:0] keep;
    logic [7:0] dec_acc;

    assign take    = item_valid && !res_full;
    assign dec_acc = 8'({val_reg, 3'b000}) + 8'({val_reg, 1'b0}) + 8'(item.digit);

    always_comb
    begin
        mode_next = mode_reg;
        cand_next = cand_reg;
        pos_next  = pos_reg;
        val_next  = val_reg;
        pend_next = pend_reg;
        emit      = 1'b0;
        err       = 1'b0;
        silent    = 1'b0;
        v         = 8'h00;
        keep      = 5'd0;
        res_wr    = 1'b0;
        res       = '0;

        unique case (mode_reg)
            xed_pkg::MODE_DRAIN:
            begin
                silent = 1'b1;
                if (item.last)
                    mode_next = xed_pkg::MODE_PLAIN;
            end
            xed_pkg::MODE_PLAIN:
            begin
                if ((pend_reg != 2'd0) && item.is_cont)
                begin
                    pend_next = pend_reg - 2'd1;
                    emit      = 1'b1;
                    v         = item.data;
                end
                else if (item.is_amp)
                begin
                    pend_next = 2'd0;
                    mode_next = xed_pkg::MODE_NAMED;
                    cand_next = 5'h1f;
                    pos_next  = 3'd0;
                end
                else
                begin
                    pend_next = item.lead_len;
                    emit      = 1'b1;
                    v         = item.data;
                end
            end
            xed_pkg::MODE_NAMED:
            begin
                if ((pos_reg == 3'd0) && item.is_hash)
                    mode_next = xed_pkg::MODE_HASH;
                else
                begin
                    for (int i = 0; i < xed_pkg::ENT_COUNT; i++)
                    begin
                        if (cand_reg[i] && (pos_reg < xed_pkg::ent_len(3'(i)))
                            && (xed_pkg::ent_char(3'(i), pos_reg) == item.data))
                        begin
                            keep[i] = 1'b1;
                            if (pos_reg + 3'd1 == xed_pkg::ent_len(3'(i)))
                            begin
                                emit = 1'b1;
                                v    = xed_pkg::ent_val(3'(i));
                            end
                        end
                    end
                    pos_next  = pos_reg + 3'd1;
                    cand_next = keep;
                    if (emit || item.is_semi)
                    begin
                        mode_next = xed_pkg::MODE_PLAIN;
                        cand_next = 5'd0;
                        pos_next  = 3'd0;
                    end
                    else if (keep == 5'd0)
                        mode_next = xed_pkg::MODE_SKIP;
                end
            end
            xed_pkg::MODE_SKIP:
            begin
                if (item.is_semi)
                    mode_next = xed_pkg::MODE_PLAIN;
            end
            xed_pkg::MODE_HASH:
            begin
                if (item.is_dec)
                begin
                    val_next  = {4'd0, item.digit};
                    mode_next = xed_pkg::MODE_DEC;
                end
                else if (item.is_x)
                begin
                    val_next  = 8'h00;
                    mode_next = xed_pkg::MODE_HEXSTART;
                end
                else if (item.is_semi)
                begin
                    mode_next = xed_pkg::MODE_PLAIN;
                    emit      = !item.last;
                end
                else
                    err = 1'b1;
            end
            xed_pkg::MODE_HEXSTART:
            begin
                if (item.is_hex)
                begin
                    val_next  = {4'd0, item.digit};
                    mode_next = xed_pkg::MODE_HEX;
                end
                else if (item.is_semi)
                begin
                    if (item.last)
                        err = 1'b1;
                    else
                    begin
                        mode_next = xed_pkg::MODE_PLAIN;
                        emit      = 1'b1;
                    end
                end
                else
                    err = 1'b1;
            end
            xed_pkg::MODE_HEX:
            begin
                if (item.is_hex)
                    val_next = {val_reg[3:0], item.digit};
                else if (item.is_semi)
                begin
                    mode_next = xed_pkg::MODE_PLAIN;
                    emit      = 1'b1;
                    v         = val_reg;
                end
                else
                    err = 1'b1;
            end
            xed_pkg::MODE_DEC:
            begin
                if (item.is_dec)
                    val_next = dec_acc;
                else if (item.is_semi)
                begin
                    mode_next = xed_pkg::MODE_PLAIN;
                    emit      = 1'b1;
                    v         = val_reg;
                end
                else
                    err = 1'b1;
            end
            default:
            begin
                silent    = 1'b1;
                mode_next = xed_pkg::MODE_PLAIN;
            end
        endcase

        // A string may only end in plain mode with no open UTF-8 sequence
        if (!silent && !err && item.last
            && ((mode_next != xed_pkg::MODE_PLAIN) || (pend_next != 2'd0)))
            err = 1'b1;

        if (!silent && (err || item.last))
        begin
            mode_next = (err && !item.last) ? xed_pkg::MODE_DRAIN : xed_pkg::MODE_PLAIN;
            cand_next = 5'd0;
            pos_next  = 3'd0;
            val_next  = 8'h00;
            pend_next = 2'd0;
        end
        else if (silent && item.last)
        begin
            cand_next = 5'd0;
            pos_next  = 3'd0;
            val_next  = 8'h00;
            pend_next = 2'd0;
        end

        if (!silent)
        begin
            if (err)
            begin
                res_wr           = take;
                res.end_of_text  = 1'b1;
                res.decode_error = 1'b1;
            end
            else if (item.last || emit)
            begin
                res_wr          = take;
                res.data        = emit ? v : 8'h00;
                res.has_byte    = emit;
                res.end_of_text = item.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= xed_pkg::MODE_PLAIN;
            cand_reg <= 5'd0;
            pos_reg  <= 3'd0;
            val_reg  <= 8'h00;
            pend_reg <= 2'd0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            cand_reg <= cand_next;
            pos_reg  <= pos_next;
            val_reg  <= val_next;
            pend_reg <= pend_next;
        end
    end

endmodule
`default_nettype wire

@@ design/xed_outq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xed_outq
// Result queue: holds decoded results until the receiver pops them.
// ----------------------------------------------------------------------------
module xed_outq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             res_wr,
    input  wire xed_pkg::result_t res,
    output logic                  res_full,
    output logic [7:0]            out_byte,
    output logic                  has_byte,
    output logic                  end_of_text,
    output logic                  decode_error,
    output logic                  empty,
    input  wire logic             pop
);

    xed_pkg::result_t mem_reg [xed_pkg::RQ_DEPTH];
    xed_pkg::result_t head;
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             wr_en;
    logic             rd_en;

    assign res_full     = (cnt_reg == 2'(xed_pkg::RQ_DEPTH));
    assign empty        = (cnt_reg == 2'd0);
    assign head         = mem_reg[rd_ptr_reg];
    assign out_byte     = head.data;
    assign has_byte     = head.has_byte;
    assign end_of_text  = head.end_of_text;
    assign decode_error = head.decode_error;
    assign wr_en        = res_wr && !res_full;
    assign rd_en        = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        cnt_next    = cnt_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

@@ design/xml_entity_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xml_entity_decoder
// Decodes XML character entities and references in a byte stream.
// ----------------------------------------------------------------------------
// Input side is a queue write port: present in_byte/in_last with push; the
// byte is taken on a clock edge where push is high and full is low. in_last
// marks the final byte of a string.
// Result side is a queue read port: while empty is low the oldest result sits
// on out_byte/has_byte/end_of_text/decode_error; pop takes it.
// Each byte gives zero or one result. An accepted byte is held in the
// classify queue; the decode stage takes it from there and writes its result
// into the result queue, whose oldest entry drives the output ports.
// Throughput is one byte per cycle while the result queue has room; the
// decode state machine updates once per byte and sets that figure.
// A two-entry queue sits on each side of the decode stage, so a stalled
// receiver fills the result queue first, then the input queue, and full rises.
// On an error an end result with decode_error is sent and the rest of the
// string is dropped up to its final byte.
// Reset empties both queues and returns the decoder to plain text mode.
// ----------------------------------------------------------------------------
module xml_entity_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       push,
    output logic            full,
    output logic [7:0]      out_byte,
    output logic            has_byte,
    output logic            end_of_text,
    output logic            decode_error,
    output logic            empty,
    input  wire logic       pop
);

    xed_pkg::item_t   item;
    logic             item_valid;
    logic             take;
    logic             res_full;
    logic             res_wr;
    xed_pkg::result_t res;

    xed_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .push       (push),
        .full       (full),
        .item       (item),
        .item_valid (item_valid),
        .take       (take)
    );

    xed_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .take       (take),
        .res_full   (res_full),
        .res_wr     (res_wr),
        .res        (res)
    );

    xed_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_wr       (res_wr),
        .res          (res),
        .res_full     (res_full),
        .out_byte     (out_byte),
        .has_byte     (has_byte),
        .end_of_text  (end_of_text),
        .decode_error (decode_error),
        .empty        (empty),
        .pop          (pop)
    );

    // Decode stage consumes only queued bytes
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> item_valid)
        else $error("decode stage took a byte from an empty queue");

    // Results are never written into a full result queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_wr |-> !res_full)
        else $error("result written while result queue full");

    // An error result always closes the string and carries no byte
    a_err_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_wr && res.decode_error) |-> (res.end_of_text && !res.has_byte))
        else $error("error result without end of text");

    // A result without a byte shows a zero byte
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !has_byte) |-> (out_byte == 8'h00))
        else $error("nonzero out_byte without has_byte");

endmodule
`default_nettype wire

@@ tb/xml_entity_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_decoder_tb
// Self-checking bench for the XML entity decoder. Short directed strings hit
// the corner cases first. Random strings built from text, named entities,
// decimal and hex references, UTF-8 sequences and broken pieces follow. A
// behavioral decoder in the bench predicts every result, and a monitor
// compares each popped result field by field. Both queue ports idle in random
// bursts, and the receiver holds off once for a long stretch to fill the block.
// ----------------------------------------------------------------------------
module xml_entity_decoder_tb;

    localparam int ENT_N       = 5;
    localparam int QUIET_LIMIT = 1000;
    localparam int LONG_HOLD   = 80;
    localparam logic [7:0] DIG_0 = 8'h30;
    localparam logic [7:0] DIG_9 = 8'h39;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_item_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_text;
    logic       decode_error;
    logic       empty;
    logic       pop = 1'b0;

    xml_entity_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .push         (push),
        .full         (full),
        .out_byte     (out_byte),
        .has_byte     (has_byte),
        .end_of_text  (end_of_text),
        .decode_error (decode_error),
        .empty        (empty),
        .pop          (pop)
    );

    always #1 clk = ~clk;

    // Bytes waiting to be pushed, and results the decoder still owes
    text_item_t       byte_q[$];
    xed_pkg::result_t decoded_q[$];
    logic [7:0]       text_buf[$];

    // Decoder state as the bench sees it
    xed_pkg::mode_t dmode = xed_pkg::MODE_PLAIN;
    logic [4:0] cand = 5'd0;
    logic [2:0] mpos = 3'd0;
    logic [7:0] refv = 8'h00;
    logic [1:0] utf8_left = 2'd0;

    bit  in_taken = 1'b0;
    bit  out_taken = 1'b0;
    bit  calm = 1'b0;
    int  send_gap = 0;
    int  pop_gap = 0;
    int  hold_ask = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    int  n_fail = 0;
    int  n_bytes = 0;
    int  n_strings = 0;
    int  n_results = 0;
    int  n_err_ends = 0;
    int  n_decoded = 0;
    int  n_full_stalls = 0;
    text_item_t       taken_item;
    xed_pkg::result_t want;

    // ------------------------------------------------------------------------
    // Entity tables
    // ------------------------------------------------------------------------
    function automatic logic [39:0] entity_text(input int e);
        case (e)
            0:       return "amp;";
            1:       return "lt;";
            2:       return "gt;";
            3:       return "quot;";
            default: return "apos;";
        endcase
    endfunction

    function automatic int entity_size(input int e);
        case (e)
            0:       return 4;
            1, 2:    return 3;
            default: return 5;
        endcase
    endfunction

    function automatic logic [7:0] entity_value(input int e);
        case (e)
            0:       return 8'h26;
            1:       return 8'h3c;
            2:       return 8'h3e;
            3:       return 8'h22;
            default: return 8'h27;
        endcase
    endfunction

    function automatic logic [7:0] entity_char(input int e, input int p);
        logic [39:0] txt;
        begin
            txt = entity_text(e);
            return txt[(entity_size(e) - 1 - p) * 8 +: 8];
        end
    endfunction

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= DIG_0 && b <= DIG_9) return int'(b - DIG_0);
        if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
        if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
        return -1;
    endfunction

    // ------------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------------
    task automatic clear_decoder();
        dmode = xed_pkg::MODE_PLAIN;
        cand = 5'd0;
        mpos = 3'd0;
        refv = 8'h00;
        utf8_left = 2'd0;
    endtask

    task automatic decode_step(input logic [7:0] b, input logic last);
        logic             emit;
        logic             err;
        logic [7:0]       v;
        logic [4:0]       keep;
        int               h;
        int               i;
        xed_pkg::result_t r;
        begin
            emit = 1'b0;
            err = 1'b0;
            v = 8'h00;
            keep = 5'd0;
            h = hex_digit(b);
            // Swallow the rest of a failed string without results
            if (dmode == xed_pkg::MODE_DRAIN) begin
                if (last) clear_decoder();
                return;
            end
            case (dmode)
                xed_pkg::MODE_PLAIN: begin
                    if (utf8_left != 2'd0 && b[7:6] == 2'b10) begin
                        utf8_left = utf8_left - 2'd1;
                        emit = 1'b1;
                        v = b;
                    end
                    else begin
                        utf8_left = 2'd0;
                        if (b == xed_pkg::CH_AMP) begin
                            dmode = xed_pkg::MODE_NAMED;
                            cand = 5'h1f;
                            mpos = 3'd0;
                        end
                        else begin
                            if (b[7:5] == 3'b110) utf8_left = 2'd1;
                            else if (b[7:4] == 4'b1110) utf8_left = 2'd2;
                            else if (b[7:3] == 5'b11110) utf8_left = 2'd3;
                            emit = 1'b1;
                            v = b;
                        end
                    end
                end
                xed_pkg::MODE_NAMED: begin
                    if (mpos == 3'd0 && b == xed_pkg::CH_HASH) begin
                        dmode = xed_pkg::MODE_HASH;
                    end
                    else begin
                        for (i = 0; i < ENT_N; i++) begin
                            if (cand[i] && int'(mpos) < entity_size(i)
                                && entity_char(i, int'(mpos)) == b) begin
                                keep[i] = 1'b1;
                                if (int'(mpos) + 1 == entity_size(i)) begin
                                    emit = 1'b1;
                                    v = entity_value(i);
                                end
                            end
                        end
                        mpos = mpos + 3'd1;
                        cand = keep;
                        if (emit || b == xed_pkg::CH_SEMI) begin
                            dmode = xed_pkg::MODE_PLAIN;
                            cand = 5'd0;
                            mpos = 3'd0;
                        end
                        else if (keep == 5'd0) begin
                            dmode = xed_pkg::MODE_SKIP;
                        end
                    end
                end
                xed_pkg::MODE_SKIP: begin
                    if (b == xed_pkg::CH_SEMI) dmode = xed_pkg::MODE_PLAIN;
                end
                xed_pkg::MODE_HASH: begin
                    if (b >= DIG_0 && b <= DIG_9) begin
                        refv = b - DIG_0;
                        dmode = xed_pkg::MODE_DEC;
                    end
                    else if (b == xed_pkg::CH_X) begin
                        refv = 8'h00;
                        dmode = xed_pkg::MODE_HEXSTART;
                    end
                    else if (b == xed_pkg::CH_SEMI) begin
                        dmode = xed_pkg::MODE_PLAIN;
                        emit = !last;
                    end
                    else begin
                        err = 1'b1;
                    end
                end
                xed_pkg::MODE_HEXSTART: begin
                    if (h >= 0) begin
                        refv = {4'h0, h[3:0]};
                        dmode = xed_pkg::MODE_HEX;
                    end
                    else if (b == xed_pkg::CH_SEMI && !last) begin
                        dmode = xed_pkg::MODE_PLAIN;
                        emit = 1'b1;
                    end
                    else begin
                        err = 1'b1;
                    end
                end
                xed_pkg::MODE_HEX: begin
                    if (h >= 0) begin
                        refv = {refv[3:0], h[3:0]};
                    end
                    else if (b == xed_pkg::CH_SEMI) begin
                        dmode = xed_pkg::MODE_PLAIN;
                        emit = 1'b1;
                        v = refv;
                    end
                    else begin
                        err = 1'b1;
                    end
                end
                xed_pkg::MODE_DEC: begin
                    if (b >= DIG_0 && b <= DIG_9) begin
                        refv = refv * 8'd10 + (b - DIG_0);
                    end
                    else if (b == xed_pkg::CH_SEMI) begin
                        dmode = xed_pkg::MODE_PLAIN;
                        emit = 1'b1;
                        v = refv;
                    end
                    else begin
                        err = 1'b1;
                    end
                end
                default: ;
            endcase

            // A string may not end inside a reference or a UTF-8 sequence
            if (!err && last && (dmode != xed_pkg::MODE_PLAIN || utf8_left != 2'd0))
                err = 1'b1;
            r.data = emit ? v : 8'h00;
            r.has_byte = emit;
            r.end_of_text = last;
            r.decode_error = 1'b0;
            if (err) begin
                clear_decoder();
                if (!last) dmode = xed_pkg::MODE_DRAIN;
                r.data = 8'h00;
                r.has_byte = 1'b0;
                r.end_of_text = 1'b1;
                r.decode_error = 1'b1;
                decoded_q = {decoded_q, r};
            end
            else if (last) begin
                clear_decoder();
                decoded_q = {decoded_q, r};
            end
            else if (emit) begin
                decoded_q = {decoded_q, r};
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] b, input logic last);
        text_item_t t;
        begin
            t.data = b;
            t.last = last;
            byte_q = {byte_q, t};
        end
    endtask

    task automatic put_text(input string s, input logic close);
        int i;
        begin
            for (i = 0; i < s.len(); i++) put_byte(s[i], close && (i == s.len() - 1));
        end
    endtask

    // Append one random piece of text to text_buf, mostly well formed
    task automatic add_token();
        int         kind;
        int         e;
        int         k;
        int         n;
        logic [7:0] c;
        begin
            kind = int'($urandom_range(0, 99));
            if (kind < 25) begin
                c = 8'($urandom_range(32, 126));
                text_buf = {text_buf, c};
            end
            else if (kind < 40) begin
                e = int'($urandom_range(0, ENT_N - 1));
                text_buf = {text_buf, xed_pkg::CH_AMP};
                for (k = 0; k < entity_size(e); k++) begin
                    c = entity_char(e, k);
                    if ($urandom_range(0, 11) == 0) c = 8'($urandom_range(97, 122));
                    text_buf = {text_buf, c};
                end
            end
            else if (kind < 52) begin
                text_buf = {text_buf, xed_pkg::CH_AMP};
                text_buf = {text_buf, xed_pkg::CH_HASH};
                n = int'($urandom_range(1, 4));
                repeat (n) begin
                    c = 8'(DIG_0 + $urandom_range(0, 9));
                    text_buf = {text_buf, c};
                end
                text_buf = {text_buf, xed_pkg::CH_SEMI};
            end
            else if (kind < 64) begin
                text_buf = {text_buf, xed_pkg::CH_AMP};
                text_buf = {text_buf, xed_pkg::CH_HASH};
                text_buf = {text_buf, xed_pkg::CH_X};
                n = int'($urandom_range(1, 3));
                repeat (n) begin
                    k = int'($urandom_range(0, 15));
                    if (k < 10) c = 8'(DIG_0 + k);
                    else if ($urandom_range(0, 1) == 1) c = 8'(8'h41 + k - 10);
                    else c = 8'(8'h61 + k - 10);
                    text_buf = {text_buf, c};
                end
                text_buf = {text_buf, xed_pkg::CH_SEMI};
            end
            else if (kind < 80) begin
                n = int'($urandom_range(1, 3));
                if (n == 1) c = 8'(8'hc0 + $urandom_range(0, 31));
                else if (n == 2) c = 8'(8'he0 + $urandom_range(0, 15));
                else c = 8'(8'hf0 + $urandom_range(0, 7));
                text_buf = {text_buf, c};
                // now and then cut the sequence short
                if ($urandom_range(0, 4) == 0) n = n - 1;
                repeat (n) begin
                    c = 8'(8'h80 + $urandom_range(0, 63));
                    text_buf = {text_buf, c};
                end
            end
            else if (kind < 90) begin
                c = 8'($urandom_range(0, 255));
                text_buf = {text_buf, c};
            end
            else if (kind < 95) begin
                text_buf = {text_buf, xed_pkg::CH_AMP};
                text_buf = {text_buf, xed_pkg::CH_HASH};
                if ($urandom_range(0, 1) == 1) text_buf = {text_buf, xed_pkg::CH_X};
                c = 8'($urandom_range(0, 255));
                text_buf = {text_buf, c};
            end
            else begin
                text_buf = {text_buf, xed_pkg::CH_AMP};
                n = int'($urandom_range(1, 4));
                repeat (n) begin
                    c = 8'($urandom_range(97, 122));
                    text_buf = {text_buf, c};
                end
                text_buf = {text_buf, xed_pkg::CH_SEMI};
            end
        end
    endtask

    task automatic add_strings(input int n_target);
        int added;
        int i;
        int n;
        begin
            added = 0;
            while (added < n_target) begin
                text_buf.delete();
                n = int'($urandom_range(1, 6));
                repeat (n) add_token();
                for (i = 0; i < text_buf.size(); i++)
                    put_byte(text_buf[i], i == text_buf.size() - 1);
                added += text_buf.size();
            end
        end
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || decoded_q.size() != 0) @(negedge clk);
    endtask

    task automatic flag_fail(input string msg);
        $display("mismatch: %s", msg);
        n_fail++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer queued bytes, hold each until the transaction completes
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (push && !in_taken) begin
                // hold the offered byte
            end
            else if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end
            else if (byte_q.size() == 0) begin
                push <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0) begin
                send_gap = int'($urandom_range(1, 7)) - 1;
                push <= 1'b0;
            end
            else begin
                push <= 1'b1;
                in_byte <= byte_q[0].data;
                in_last <= byte_q[0].last;
            end
        end
    end

    // Receiver: random pop bursts, plus one long hold on request
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0) begin
                pop_gap = int'($urandom_range(1, 7)) - 1;
                pop <= 1'b0;
            end
            else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on accepted bytes, check popped results
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            in_taken = push && !full;
            out_taken = pop && !empty;
            if (push && full) n_full_stalls++;
            if (in_taken) begin
                taken_item = byte_q.pop_front();
                decode_step(taken_item.data, taken_item.last);
                n_bytes++;
                if (taken_item.last) n_strings++;
            end
            if (out_taken) begin
                if (decoded_q.size() == 0) begin
                    flag_fail($sformatf("result %0d arrived with nothing expected", n_results));
                end
                else begin
                    want = decoded_q.pop_front();
                    if (out_byte !== want.data)
                        flag_fail($sformatf("result %0d out_byte %h, want %h",
                                            n_results, out_byte, want.data));
                    if (has_byte !== want.has_byte)
                        flag_fail($sformatf("result %0d has_byte %b, want %b",
                                            n_results, has_byte, want.has_byte));
                    if (end_of_text !== want.end_of_text)
                        flag_fail($sformatf("result %0d end_of_text %b, want %b",
                                            n_results, end_of_text, want.end_of_text));
                    if (decode_error !== want.decode_error)
                        flag_fail($sformatf("result %0d decode_error %b, want %b",
                                            n_results, decode_error, want.decode_error));
                end
                if (decode_error === 1'b1) n_err_ends++;
                if (has_byte === 1'b1) n_decoded++;
                n_results++;
            end
            if (in_taken || out_taken) quiet_cycles = 0;
            else quiet_cycles++;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: %0d cycles without a transaction", quiet_cycles);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes of the byte, an entity, an invalid lead byte at the end
        put_byte(8'h00, 1'b0);
        put_text("&lt;", 1'b0);
        put_byte(8'hff, 1'b1);
        // empty decimal reference at the end gives no byte
        put_text("&#;", 1'b1);
        // empty hex reference at the end fails
        put_text("&#x;", 1'b1);
        // stray continuation, bare semicolon entity, broken UTF-8 sequence
        put_byte(8'h80, 1'b0);
        put_text("&;", 1'b0);
        put_byte(8'hc3, 1'b0);
        put_text("A", 1'b1);
        // bad byte in a reference, then drop the tail
        put_text("&#q", 1'b0);
        put_text("zz", 1'b1);
        wait_drained();

        // fill the block while the receiver holds off
        add_strings(350);
        hold_ask++;
        wait_drained();

        add_strings(350);
        wait_drained();

        // run out the end at full rate on both sides
        calm = 1'b1;
        add_strings(300);
        wait_drained();
        repeat (10) @(negedge clk);

        $display("covered %0d strings, %0d bytes, %0d results (%0d decoded bytes)",
                 n_strings, n_bytes, n_results, n_decoded);
        $display("%0d strings closed on a decode error; input stalled on full %0d times",
                 n_err_ends, n_full_stalls);
        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
